// File: sv/hdcs_pkg.sv
// ----------------------------------------------------------------------------
// hdcs_pkg
// Shared types, constants and table functions for the decomposition cost
// selector.
// ----------------------------------------------------------------------------
package hdcs_pkg;

   localparam int CNT_W  = 6;
   localparam int COST_W = 8;

   localparam int BIN_COST_W = 7;
   localparam int LUC_COST_W = 4;
   localparam int FIB_COST_W = 5;
   localparam int BEST_W     = 7;
   localparam int METHOD_W   = 2;
   localparam int RSP_W      = 32;

   localparam logic [METHOD_W-1:0] METHOD_BINARY = 2'd0;
   localparam logic [METHOD_W-1:0] METHOD_LUCAS  = 2'd1;
   localparam logic [METHOD_W-1:0] METHOD_FIB    = 2'd2;

   typedef logic [1:0] step_type;

   localparam step_type STEP_ACCEPT = 2'd0;
   localparam step_type STEP_WALK   = 2'd1;
   localparam step_type STEP_FINISH = 2'd2;

   typedef enum logic [1:0] {
      COND_NONE     = 2'd0,
      COND_NO_INPUT = 2'd1,
      COND_WALK_MORE = 2'd2,
      COND_OUT_BUSY = 2'd3
   } cond_type;

   typedef struct packed {
      logic     accept;
      logic     walk;
      logic     finish;
      cond_type cond;
      step_type target;
      step_type next;
   } ucode_type;

   typedef struct packed {
      logic accept;
      logic walk;
      logic finish;
   } ctrl_type;

   typedef struct packed {
      logic in_valid;
      logic walk_last;
      logic out_busy;
   } status_type;

   typedef struct packed {
      logic [METHOD_W-1:0]   low_method;
      logic [BEST_W-1:0]     low_cost;
      logic [FIB_COST_W-1:0] zeck_cost;
      logic [LUC_COST_W-1:0] luc_cost;
      logic [BIN_COST_W-1:0] bin_cost;
   } result_type;

   // Fibonacci table entry k: 1, 2, 3, 5, ...
   function automatic logic [63:0] fib_at(input int k);
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] n;
      a = 64'd1;
      b = 64'd2;
      for (int i = 0; i < k; i++) begin
         n = a + b;
         a = b;
         b = n;
      end
      return a;
   endfunction

   // Lucas number L(i), with L(0) = 2 and L(1) = 1
   function automatic logic [63:0] lucas_at(input int i);
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] n;
      a = 64'd2;
      b = 64'd1;
      for (int j = 0; j < i; j++) begin
         n = a + b;
         a = b;
         b = n;
      end
      return a;
   endfunction

endpackage

// File: sv/hdcs_useq.sv
// ----------------------------------------------------------------------------
// hdcs_useq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module hdcs_useq (
   input  logic                clock,
   input  logic                reset,
   input  hdcs_pkg::status_type status,
   output hdcs_pkg::ctrl_type   ctrl
);
   import hdcs_pkg::*;

   step_type  pc_ff;
   step_type  pc_in;
   ucode_type word;
   logic      take;

   always_comb begin
      word = '{accept: 1'b0, walk: 1'b0, finish: 1'b0, cond: COND_NONE,
               target: STEP_ACCEPT, next: STEP_ACCEPT};
      unique case (pc_ff)
         STEP_ACCEPT: begin
            word = '{accept: 1'b1, walk: 1'b0, finish: 1'b0, cond: COND_NO_INPUT,
                     target: STEP_ACCEPT, next: STEP_WALK};
         end
         STEP_WALK: begin
            word = '{accept: 1'b0, walk: 1'b1, finish: 1'b0, cond: COND_WALK_MORE,
                     target: STEP_WALK, next: STEP_FINISH};
         end
         STEP_FINISH: begin
            word = '{accept: 1'b0, walk: 1'b0, finish: 1'b1, cond: COND_OUT_BUSY,
                     target: STEP_FINISH, next: STEP_ACCEPT};
         end
         default: begin
            word = '{accept: 1'b0, walk: 1'b0, finish: 1'b0, cond: COND_NONE,
                     target: STEP_ACCEPT, next: STEP_ACCEPT};
         end
      endcase
   end

   always_comb begin
      unique case (word.cond)
         COND_NONE:      take = 1'b0;
         COND_NO_INPUT:  take = ~status.in_valid;
         COND_WALK_MORE: take = ~status.walk_last;
         COND_OUT_BUSY:  take = status.out_busy;
         default:        take = 1'b0;
      endcase
      pc_in = take ? word.target : word.next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_ACCEPT;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctrl = '{accept: word.accept, walk: word.walk, finish: word.finish};

endmodule

// File: sv/hdcs_datapath.sv
// ----------------------------------------------------------------------------
// hdcs_datapath
// Greedy table walks and bit-serial binary cost, one table entry per step.
// ----------------------------------------------------------------------------
module hdcs_datapath #(
   parameter int TABLE_TOP  = 40,
   parameter int VALUE_BITS = 28
) (
   input  logic                  clock,
   input  hdcs_pkg::ctrl_type     ctrl,
   input  logic                  in_valid,
   input  logic [VALUE_BITS-1:0] value,
   output logic                  walk_last,
   output hdcs_pkg::result_type   result
);
   import hdcs_pkg::*;

   localparam int FIB_DEPTH   = TABLE_TOP + 1;
   localparam int LUCAS_DEPTH = (TABLE_TOP + 2) / 3;
   localparam int WALK_LEN    = (FIB_DEPTH > VALUE_BITS) ? FIB_DEPTH : VALUE_BITS;
   localparam int IDX_W       = $clog2(WALK_LEN);
   localparam int ENT_W       = VALUE_BITS + 1;
   localparam logic [ENT_W-1:0] ENT_HUGE = {1'b1, {VALUE_BITS{1'b0}}};
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WALK_LEN - 1);

   logic [ENT_W-1:0] fib_tab [WALK_LEN];
   logic [ENT_W-1:0] luc_tab [WALK_LEN];

   // tables held in walk order, largest entry first
   for (genvar g = 0; g < WALK_LEN; g++) begin : g_tab
      if (g < FIB_DEPTH) begin : g_fib
         localparam logic [63:0] FV = fib_at(FIB_DEPTH - 1 - g);
         assign fib_tab[g] = ((FV >> VALUE_BITS) != 64'd0) ? ENT_HUGE : FV[ENT_W-1:0];
      end else begin : g_fib_pad
         assign fib_tab[g] = ENT_HUGE;
      end
      if (g < LUCAS_DEPTH) begin : g_luc
         localparam logic [63:0] LV = lucas_at(3 * (LUCAS_DEPTH - 1 - g) + 1);
         assign luc_tab[g] = ((LV >> VALUE_BITS) != 64'd0) ? ENT_HUGE : LV[ENT_W-1:0];
      end else begin : g_luc_pad
         assign luc_tab[g] = ENT_HUGE;
      end
   end

   logic [IDX_W-1:0]      idx_ff,    idx_in;
   logic [VALUE_BITS-1:0] rem_f_ff,  rem_f_in;
   logic [VALUE_BITS-1:0] rem_l_ff,  rem_l_in;
   logic                  skip_ff,   skip_in;
   logic [CNT_W-1:0]      fib_n_ff,  fib_n_in;
   logic [CNT_W-1:0]      luc_n_ff,  luc_n_in;
   logic [VALUE_BITS-1:0] vsh_ff,    vsh_in;
   logic [VALUE_BITS-1:0] vm1_ff,    vm1_in;
   logic [CNT_W-1:0]      pop_ff,    pop_in;
   logic [CNT_W-1:0]      blen_ff,   blen_in;

   logic [ENT_W-1:0] fe;
   logic [ENT_W-1:0] le;
   logic             fib_take;
   logic             luc_take;

   assign fe       = fib_tab[idx_ff];
   assign le       = luc_tab[idx_ff];
   assign fib_take = ~skip_ff && (fe <= {1'b0, rem_f_ff});
   assign luc_take = (le <= {1'b0, rem_l_ff});

   always_comb begin
      idx_in   = idx_ff;
      rem_f_in = rem_f_ff;
      rem_l_in = rem_l_ff;
      skip_in  = skip_ff;
      fib_n_in = fib_n_ff;
      luc_n_in = luc_n_ff;
      vsh_in   = vsh_ff;
      vm1_in   = vm1_ff;
      pop_in   = pop_ff;
      blen_in  = blen_ff;
      if (ctrl.accept && in_valid) begin
         idx_in   = '0;
         rem_f_in = value;
         rem_l_in = value;
         skip_in  = 1'b0;
         fib_n_in = '0;
         luc_n_in = '0;
         vsh_in   = value;
         vm1_in   = (value == '0) ? '0 : value - VALUE_BITS'(1);
         pop_in   = '0;
         blen_in  = '0;
      end else if (ctrl.walk) begin
         idx_in  = (idx_ff == IDX_LAST) ? idx_ff : idx_ff + IDX_W'(1);
         skip_in = fib_take;
         if (fib_take) begin
            rem_f_in = rem_f_ff - fe[VALUE_BITS-1:0];
            fib_n_in = fib_n_ff + CNT_W'(1);
         end
         if (luc_take) begin
            rem_l_in = rem_l_ff - le[VALUE_BITS-1:0];
            luc_n_in = luc_n_ff + CNT_W'(1);
         end
         pop_in = pop_ff + CNT_W'(vsh_ff[0]);
         vsh_in = vsh_ff >> 1;
         if (vm1_ff != '0) begin
            blen_in = blen_ff + CNT_W'(1);
         end
         vm1_in = vm1_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      rem_f_ff <= rem_f_in;
      rem_l_ff <= rem_l_in;
      skip_ff  <= skip_in;
      fib_n_ff <= fib_n_in;
      luc_n_ff <= luc_n_in;
      vsh_ff   <= vsh_in;
      vm1_ff   <= vm1_in;
      pop_ff   <= pop_in;
      blen_ff  <= blen_in;
   end

   assign walk_last = (idx_ff == IDX_LAST);

   logic signed [COST_W-1:0] bin_c;
   logic signed [COST_W-1:0] luc_c;
   logic signed [COST_W-1:0] fib_c;
   logic signed [COST_W-1:0] best_c;
   logic [METHOD_W-1:0]      method;

   always_comb begin
      bin_c  = $signed(COST_W'(blen_ff)) + $signed(COST_W'(pop_ff)) - COST_W'(2);
      luc_c  = (luc_n_ff == '0) ? '0 : $signed(COST_W'(luc_n_ff - CNT_W'(1)));
      fib_c  = (fib_n_ff == '0) ? '0 : $signed(COST_W'(fib_n_ff - CNT_W'(1)));
      best_c = bin_c;
      if (luc_c < best_c) begin
         best_c = luc_c;
      end
      if (fib_c < best_c) begin
         best_c = fib_c;
      end
      priority if (best_c == bin_c) begin
         method = METHOD_BINARY;
      end else if (best_c == luc_c) begin
         method = METHOD_LUCAS;
      end else begin
         method = METHOD_FIB;
      end
      result.bin_cost   = bin_c[BIN_COST_W-1:0];
      result.luc_cost   = luc_c[LUC_COST_W-1:0];
      result.zeck_cost  = fib_c[FIB_COST_W-1:0];
      result.low_cost   = best_c[BEST_W-1:0];
      result.low_method = method;
   end

endmodule

// File: sv/hybrid_decomposition_cost_select.sv
// ----------------------------------------------------------------------------
// hybrid_decomposition_cost_select
// Binary, greedy Lucas and Zeckendorf addition costs of one value, and the
// cheapest of the three.
// ----------------------------------------------------------------------------
// A word is taken in one accept step, followed by one walk step per entry of
// the Fibonacci table or per value bit, whichever is more (the Lucas table and
// the bit-serial popcount and bit length run in the same steps), and one
// finish step that loads the output register. The next word is taken in the
// accept step that follows the finish step, so a new word is taken only once
// the previous one is through. The finish step holds while the previous
// result still waits unread; a loaded result waits in the output register
// while the next word is taken. Bits of req_tdata above VALUE_BITS are
// ignored.
module hybrid_decomposition_cost_select #(
   parameter int TABLE_TOP  = 40,
   parameter int VALUE_BITS = 28
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0]   req_tdata,  // value
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // bin_cost, luc_cost, zeck_cost, low_cost, low_method
   output logic [hdcs_pkg::RSP_W-1:0]                rsp_tdata
);
   import hdcs_pkg::*;

   localparam int RES_W = $bits(result_type);

   ctrl_type   ctrl;
   status_type status;
   result_type result;
   logic       walk_last;
   logic       out_busy;
   logic       fin_fire;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [RES_W-1:0] rsp_data_ff,  rsp_data_in;

   assign out_busy = rsp_valid_ff & ~rsp_tready;
   assign fin_fire = ctrl.finish & ~out_busy;

   assign status = '{in_valid: req_tvalid, walk_last: walk_last, out_busy: out_busy};

   hdcs_useq u_useq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   hdcs_datapath #(
      .TABLE_TOP  (TABLE_TOP),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock     (clock),
      .ctrl      (ctrl),
      .in_valid  (req_tvalid),
      .value     (req_tdata[VALUE_BITS-1:0]),
      .walk_last (walk_last),
      .result    (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (fin_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = ctrl.accept;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);

endmodule

// File: test/tb_hybrid_decomposition_cost_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hybrid_decomposition_cost_select
// Drives values into the decomposition cost selector and checks every result
// word, field by field, against costs worked out here from the binary method,
// a greedy pass over the Lucas numbers at indices 1 mod 3 and a Zeckendorf
// pass over Fibonacci numbers. Both sides idle at random, bar back-to-back.
// ----------------------------------------------------------------------------
module tb_hybrid_decomposition_cost_select;
   import hdcs_pkg::*;

   localparam int FIB_ENTRIES   = 41;
   localparam int LUCAS_ENTRIES = 14;
   localparam int STALL_LIMIT   = 2000;
   localparam int TAIL_CYCLES   = 60;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [31:0]         req_tdata;  // value
   logic                rsp_tvalid;
   logic                rsp_tready;
   // bin_cost, luc_cost, zeck_cost, low_cost, low_method
   logic [RSP_W-1:0]    rsp_tdata;

   logic [63:0]         fib_tab [FIB_ENTRIES];
   logic [63:0]         lucas_tab [LUCAS_ENTRIES];
   result_type          pending_costs [$];
   bit                  idle_on;
   int                  errors = 0;
   int                  quiet_cycles = 0;

   hybrid_decomposition_cost_select u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void build_tables();
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] n;
      int k;
      a = 64'd2;
      b = 64'd1;
      k = 0;
      for (int i = 0; i <= FIB_ENTRIES - 1; i++) begin
         if (i % 3 == 1 && k < LUCAS_ENTRIES) begin
            lucas_tab[k] = a;
            k++;
         end
         n = a + b;
         a = b;
         b = n;
      end
      fib_tab[0] = 64'd1;
      fib_tab[1] = 64'd2;
      for (int i = 2; i < FIB_ENTRIES; i++) fib_tab[i] = fib_tab[i-1] + fib_tab[i-2];
   endfunction

   function automatic result_type predict_costs(logic [31:0] word);
      logic [63:0] v;
      logic [63:0] rem;
      int bin_cost;
      int luc_terms;
      int zeck_terms;
      int luc_cost;
      int zeck_cost;
      int best;
      int width;
      int i;
      result_type r;
      v = {36'd0, word[27:0]};
      if (v == 0) begin
         bin_cost = -2;
      end else begin
         width = 0;
         for (int j = 0; j < 64; j++) if ((v - 1) >> j != 0) width = j + 1;
         bin_cost = width - 1 + $countones(v) - 1;
      end
      luc_terms = 0;
      rem = v;
      for (int j = LUCAS_ENTRIES - 1; j >= 0 && rem > 0; j--) begin
         if (lucas_tab[j] <= rem) begin
            luc_terms++;
            rem -= lucas_tab[j];
         end
      end
      zeck_terms = 0;
      rem = v;
      i = FIB_ENTRIES - 1;
      while (i >= 0 && rem > 0) begin
         if (fib_tab[i] <= rem) begin
            zeck_terms++;
            rem -= fib_tab[i];
            i--;
         end
         i--;
      end
      luc_cost = luc_terms > 0 ? luc_terms - 1 : 0;
      zeck_cost = zeck_terms > 0 ? zeck_terms - 1 : 0;
      best = bin_cost;
      if (luc_cost < best) best = luc_cost;
      if (zeck_cost < best) best = zeck_cost;
      r = '0;
      r.bin_cost  = BIN_COST_W'(bin_cost);
      r.luc_cost  = LUC_COST_W'(luc_cost);
      r.zeck_cost = FIB_COST_W'(zeck_cost);
      r.low_cost  = BEST_W'(best);
      if (best == bin_cost) r.low_method = METHOD_BINARY;
      else if (best == luc_cost) r.low_method = METHOD_LUCAS;
      else r.low_method = METHOD_FIB;
      return r;
   endfunction

   function automatic logic [31:0] random_value();
      logic [31:0] word;
      int w;
      case ($urandom_range(0, 4))
         0: word = $urandom;
         1: word = $urandom_range(0, 300);
         2: begin
            word = 32'(fib_tab[$urandom_range(0, 39)] + lucas_tab[$urandom_range(0, 13)]);
            if ($urandom_range(0, 1)) word = word - $urandom_range(0, 3);
         end
         3: begin
            word = 32'd1 << $urandom_range(0, 27);
            word = word + $urandom_range(0, 2) - 1;
         end
         default: begin
            w = $urandom_range(1, 28);
            word = $urandom & ((32'd1 << w) - 1);
         end
      endcase
      if ($urandom_range(0, 7) == 0) word[31:28] = 4'($urandom_range(0, 15));
      return word;
   endfunction

   task automatic send_value(input logic [31:0] word);
      while (idle_on && $urandom_range(0, 99) < 26) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_costs.insert(pending_costs.size(), predict_costs(word));
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_costs.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string name, input int expected, input int actual);
      if (expected != actual) begin
         $error("%s: expected %0d, actual %0d", name, expected, actual);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_tready <= !(idle_on && $urandom_range(0, 99) < 26);
   end

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(result_type)-1:0];
            if (pending_costs.size() == 0) begin
               $error("result word 0x%08h with nothing pending", rsp_tdata);
               errors++;
            end else begin
               want = pending_costs.pop_front();
               check_field("bin_cost", $signed(want.bin_cost), $signed(got.bin_cost));
               check_field("luc_cost", want.luc_cost, got.luc_cost);
               check_field("zeck_cost", want.zeck_cost, got.zeck_cost);
               check_field("low_cost", $signed(want.low_cost), $signed(got.low_cost));
               check_field("low_method", want.low_method, got.low_method);
            end
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("hybrid_decomposition_cost_select: mismatch");
            $finish;
         end
      end
   end

   task automatic test_directed_values();
      logic [31:0] words [$];
      words = {32'd1, 32'd0, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd8,
               32'd29, 32'd30, 32'd123, 32'd144, 32'd233,
               32'h0FFF_FFFF, 32'h0800_0000, 32'h07FF_FFFF,
               32'h0AAA_AAAA, 32'h0555_5555, 32'hF000_0001,
               32'hFFFF_FFFF, 32'hA000_0000, 32'h5000_0030,
               32'(lucas_tab[13]), 32'(fib_tab[39])};
      foreach (words[i]) send_value(words[i]);
   endtask

   task automatic test_random_stream(input int count);
      repeat (count) send_value(random_value());
   endtask

   task automatic test_back_to_back(input int count);
      idle_on = 1'b0;
      repeat (count) send_value(random_value());
      idle_on = 1'b1;
   endtask

   initial begin
      idle_on      = 1'b1;
      build_tables();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      rsp_tready <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_values();
      wait_for_results();
      test_random_stream(450);
      wait_for_results();
      test_back_to_back(350);
      test_random_stream(325);
      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (errors == 0 && pending_costs.size() == 0) begin
         $display("hybrid_decomposition_cost_select: match");
      end else begin
         $display("hybrid_decomposition_cost_select: mismatch");
      end
      $finish;
   end

endmodule
